FILE: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Shared constants, codes and word types for the deframer.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_LEN = 31;

  localparam logic [7:0]  END_BYTE       = 8'hA8;
  localparam logic [7:0]  ESC_BYTE       = 8'hA9;
  localparam logic [7:0]  ESC_MASK       = 8'h20;
  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFE;
  localparam int          MIN_FRAME      = 4;
  localparam int          HDR_DEPTH      = 5;
  localparam int          CNT_W          = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_DEVICE_ADDR = 1'b0;

  typedef enum logic {
    KIND_DATA,
    KIND_END
  } sfr_kind_e;

  typedef struct packed {
    sfr_kind_e  kind;
    logic [7:0] value;
    logic       busy;
  } sfr_word_t;

  typedef struct packed {
    logic      push;
    sfr_word_t word;
  } sfr_push_t;

  typedef struct packed {
    logic      empty;
    sfr_word_t word;
  } sfr_head_t;

endpackage

FILE: rtl/core/sfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver channels
// Valid/ready channels for received bytes and decoded commands.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       actuator_busy;

  modport source (output valid, rx_byte, actuator_busy, input ready);
  modport sink   (input valid, rx_byte, actuator_busy, output ready);
endinterface

interface sfr_res_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic [7:0]  command_code;
  logic [15:0] aux_value;

  modport source (output valid, frame_status, command_code, aux_value, input ready);
  modport sink   (input valid, frame_status, command_code, aux_value, output ready);
endinterface

FILE: rtl/core/sfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver front end
// Accepts raw bytes, strips escapes and queues data and end words.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  sfr_rx_if.sink             rx_i,
  input  logic               full_i,
  output sfr_pkg::sfr_push_t push_o
);
  import sfr_pkg::*;

  logic esc_q, esc_d;
  logic accept;
  logic is_end, is_esc;

  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign is_end     = (rx_i.rx_byte == END_BYTE);
  assign is_esc     = (rx_i.rx_byte == ESC_BYTE);

  always_comb begin
    esc_d = esc_q;
    if (accept && is_esc) begin
      esc_d = 1'b1;
    end else if (accept && !is_end) begin
      esc_d = 1'b0;
    end
  end

  always_comb begin
    push_o.push       = accept && !is_esc;
    push_o.word.kind  = is_end ? KIND_END : KIND_DATA;
    push_o.word.value = rx_i.rx_byte | (esc_q ? ESC_MASK : 8'h00);
    push_o.word.busy  = rx_i.actuator_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

FILE: rtl/core/sfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver word queue
// Short queue between the front end and the frame checker.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfr_pkg::sfr_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output sfr_pkg::sfr_head_t head_o
);
  import sfr_pkg::*;

  sfr_word_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.word  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && !head_o.empty;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i.push && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/sfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver back end
// Stores header bytes, keeps count and checksum, and emits commands.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfr_pkg::sfr_head_t head_i,
  input  logic [15:0]        device_address_i,
  output logic               pop_o,
  sfr_res_if.source          res_o
);
  import sfr_pkg::*;

  logic [7:0]       hdr_q [HDR_DEPTH];
  logic [7:0]       hdr_d [HDR_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       xor_q, xor_d;
  logic             vld_q, vld_d;
  logic             status_q, status_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      aux_q, aux_d;
  logic             take;
  logic [15:0]      addr;
  logic             frame_ok;

  assign pop_o = !vld_q || res_o.ready;
  assign take  = pop_o && !head_i.empty;
  assign addr  = {hdr_q[0], hdr_q[1]};

  assign frame_ok = (cnt_q >= CNT_W'(MIN_FRAME)) && (xor_q == 8'h00)
                    && ((addr == BROADCAST_ADDR) || (addr == device_address_i));

  always_comb begin
    hdr_d    = hdr_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    vld_d    = vld_q && !res_o.ready;
    status_d = status_q;
    cmd_d    = cmd_q;
    aux_d    = aux_q;
    if (take) begin
      case (head_i.word.kind)
        KIND_END: begin
          if (frame_ok) begin
            vld_d    = 1'b1;
            status_d = head_i.word.busy;
            cmd_d    = hdr_q[2];
            aux_d    = {hdr_q[3], hdr_q[4]};
          end
          cnt_d = '0;
          xor_d = '0;
        end
        KIND_DATA: begin
          if (cnt_q <= CNT_W'(MAX_LEN)) begin
            for (int i = 0; i < HDR_DEPTH; i++) begin
              if (cnt_q == CNT_W'(i)) begin
                hdr_d[i] = head_i.word.value;
              end
            end
            xor_d = xor_q ^ head_i.word.value;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.frame_status = status_q;
  assign res_o.command_code = cmd_q;
  assign res_o.aux_value    = aux_q;

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    cmd_q    <= cmd_d;
    aux_q    <= aux_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
        hdr_q[i] <= '0;
      end
      cnt_q <= '0;
      xor_q <= '0;
      vld_q <= 1'b0;
    end else begin
      hdr_q <= hdr_d;
      cnt_q <= cnt_d;
      xor_q <= xor_d;
      vld_q <= vld_d;
    end
  end

endmodule

FILE: rtl/core/stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver
// Deframes a byte-stuffed command stream and emits checked commands.
// ----------------------------------------------------------------------------
//  port    | dir | words
//  rx_i    | in  | received byte plus actuator busy flag
//  res_o   | out | frame status, command code, aux value
//  apb     | in  | device address register at byte 0
//
//  One byte per cycle while the result channel drains.
//  A command passes the queue, then the output register, after its end byte.
//  Reset clears the escape flag, queue, header, count, checksum, result valid and device address.
//  A stalled result holds the back end; the two-word queue then fills and
//  drops rx_i.ready.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sfr_rx_if.sink                           rx_i,
  sfr_res_if.source                        res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import sfr_pkg::*;

  logic [15:0] dev_addr_q;
  sfr_push_t   push;
  sfr_head_t   head;
  logic        full;
  logic        pop;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_DEVICE_ADDR);
  assign prdata  = reg_sel ? {{(APB_DATA_W-16){1'b0}}, dev_addr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dev_addr_q <= pwdata[15:0];
    end
  end

  sfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push)
  );

  sfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  sfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .device_address_i (dev_addr_q),
    .pop_o            (pop),
    .res_o            (res_o)
  );

endmodule

FILE: rtl/core/sfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver checker
// Port-level checks on result flow, back pressure and the register port.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_status_i,
  input logic [7:0]  res_cmd_i,
  input logic [15:0] res_aux_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [2:0]  paddr_i,
  input logic [31:0] pwdata_i,
  input logic [31:0] prdata_i,
  input logic        pready_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_status_i) && $stable(res_cmd_i)
                                    && $stable(res_aux_i))
    else $error("result changed while stalled");

  a_rx_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i && !rx_ready_i |=> rx_ready_i)
    else $error("input stalled with idle output");

  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && pready_i && !paddr_i[2]
    |=> paddr_i[2] || prdata_i == {16'h0000, $past(pwdata_i[15:0])})
    else $error("device address readback mismatch");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_ready_i   (rx_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.frame_status),
  .res_cmd_i    (res_o.command_code),
  .res_aux_i    (res_o.aux_value),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata),
  .pready_i     (pready)
);
